// ===== rtl/core/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types and constants of the beep pattern task queue
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int QUANTUM_W  = 10;
    localparam int RATE_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int IVL_W      = 8;
    localparam int TASK_W     = COUNT_W + IVL_W;
    localparam int SPAN_W     = 12;
    localparam int ELAPSED_W  = 16;
    localparam int LEVEL_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 1'b1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 10'd10;
    localparam logic [RATE_W-1:0]    RATE_RESET    = 8'd100;

    typedef struct packed {
        logic add_write;
        logic add_refuse;
        logic pop;
        logic exec;
    } bpq_cmd_t;

    typedef struct packed {
        logic full;
        logic pop_ok;
    } bpq_status_t;

endpackage

// ===== rtl/core/bpq_ram.sv =====
// ----------------------------------------------------------------------------
// bpq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/bpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpq_ctrl
// controller: accepts words, sequences queue pop and task step
// ----------------------------------------------------------------------------
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        op,
    input  bpq_status_t status,
    output bpq_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_ADD)
                    begin
                        cmd.add_write  = !status.full;
                        cmd.add_refuse = status.full;
                    end
                    else
                    begin
                        cmd.pop    = status.pop_ok;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy      <= (state_next == ST_EXEC);
        end
    end

endmodule

// ===== rtl/core/bpq_dp.sv =====
// ----------------------------------------------------------------------------
// bpq_dp
// datapath: task ring queue, beep timing, gap counter and result registers
// ----------------------------------------------------------------------------
module bpq_dp
    import bpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpq_cmd_t              cmd,
    output bpq_status_t           status,
    input  logic [COUNT_W-1:0]    beep_count,
    input  logic [IVL_W-1:0]      interval_10ms,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  add_accepted,
    output logic                  buzzer_on,
    output logic                  task_finished,
    output logic [LEVEL_W-1:0]    queue_level
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_LEVEL = FW'(QUEUE_DEPTH);

    logic [QUANTUM_W-1:0] quantum_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic [AW-1:0]        wr_ptr_reg;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;
    logic [COUNT_W-1:0]   cur_count_reg;
    logic [IVL_W-1:0]     cur_ivl_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [COUNT_W-1:0]   beeps_reg;
    logic                 buzzer_reg;
    logic                 last_over_reg;
    logic                 gap_reg;
    logic [RATE_W-1:0]    gap_ticks_reg;
    logic                 popped_reg;

    logic [TASK_W-1:0]    ram_rdata;
    logic [FW+LEVEL_W-1:0] fill_ext;

    // task step
    logic [COUNT_W-1:0]   cnt;
    logic [IVL_W-1:0]     ivl;
    logic [SPAN_W-1:0]    span;
    logic [SPAN_W:0]      span2;
    logic                 instant_end;
    logic [ELAPSED_W-1:0] el_sum;
    logic [COUNT_W-1:0]   beeps_inc;
    logic                 fin;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [COUNT_W-1:0]   beeps_next;
    logic                 buzzer_next;
    logic                 gap_any;
    logic [RATE_W-1:0]    gap_inc;
    logic                 gap_next;
    logic [RATE_W-1:0]    gap_ticks_next;

    bpq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (wr_ptr_reg),
        .wdata ({beep_count, interval_10ms}),
        .re    (cmd.pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign status.full   = (fill_reg == FULL_LEVEL);
    assign status.pop_ok = !gap_reg && (fill_reg != '0) && last_over_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.add_write)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    assign fill_ext = {{LEVEL_W{1'b0}}, fill_next};

    always_comb
    begin
        cnt       = popped_reg ? ram_rdata[TASK_W-1:IVL_W] : cur_count_reg;
        ivl       = popped_reg ? ram_rdata[IVL_W-1:0] : cur_ivl_reg;
        span      = {1'b0, ivl, 3'b000} + {3'b000, ivl, 1'b0};
        span2     = {span, 1'b0};
        el_sum    = elapsed_reg + ELAPSED_W'(quantum_reg);
        beeps_inc = beeps_reg + 1'b1;
        instant_end = ((cnt == '0) && (ivl == '0)) ||
                      (span < SPAN_W'(quantum_reg));

        fin          = 1'b0;
        elapsed_next = el_sum;
        beeps_next   = beeps_reg;
        buzzer_next  = buzzer_reg;
        priority if (instant_end)
        begin
            elapsed_next = '0;
            beeps_next   = '0;
            buzzer_next  = 1'b0;
            fin          = 1'b1;
        end
        else if (el_sum < ELAPSED_W'(span))
        begin
            buzzer_next = 1'b1;
        end
        else if (el_sum < ELAPSED_W'(span2))
        begin
            buzzer_next = 1'b0;
        end
        else
        begin
            elapsed_next = '0;
            beeps_next   = beeps_inc;
            if (beeps_inc == cnt)
            begin
                buzzer_next = 1'b0;
                beeps_next  = '0;
                fin         = 1'b1;
            end
        end

        gap_any        = gap_reg || fin;
        gap_inc        = gap_ticks_reg + 1'b1;
        gap_next       = gap_reg;
        gap_ticks_next = gap_ticks_reg;
        if (gap_any)
        begin
            if (gap_inc >= rate_reg)
            begin
                gap_next       = 1'b0;
                gap_ticks_next = '0;
            end
            else
            begin
                gap_next       = 1'b1;
                gap_ticks_next = gap_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= QUANTUM_RESET;
            rate_reg      <= RATE_RESET;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            cur_count_reg <= '0;
            cur_ivl_reg   <= '0;
            elapsed_reg   <= '0;
            beeps_reg     <= '0;
            buzzer_reg    <= 1'b0;
            last_over_reg <= 1'b1;
            gap_reg       <= 1'b0;
            gap_ticks_reg <= '0;
            popped_reg    <= 1'b0;
            done          <= 1'b0;
            add_accepted  <= 1'b0;
            task_finished <= 1'b0;
            queue_level   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_QUANTUM: quantum_reg <= cfg_data[QUANTUM_W-1:0];
                    CFG_RATE:    rate_reg    <= cfg_data[RATE_W-1:0];
                endcase
            end

            fill_reg <= fill_next;
            if (cmd.add_write)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (cmd.pop || cmd.exec)
            begin
                popped_reg <= cmd.pop;
            end

            if (cmd.exec)
            begin
                elapsed_reg   <= elapsed_next;
                beeps_reg     <= beeps_next;
                buzzer_reg    <= buzzer_next;
                last_over_reg <= fin;
                cur_count_reg <= fin ? '0 : cnt;
                cur_ivl_reg   <= fin ? '0 : ivl;
                gap_reg       <= gap_next;
                gap_ticks_reg <= gap_ticks_next;
            end

            done <= cmd.add_write || cmd.add_refuse || cmd.exec;
            if (cmd.add_write || cmd.add_refuse || cmd.exec)
            begin
                add_accepted  <= cmd.add_write;
                task_finished <= cmd.exec && fin;
                queue_level   <= fill_ext[LEVEL_W-1:0];
            end
        end
    end

    assign buzzer_on = buzzer_reg;

    fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_LEVEL)
        else $error("queue fill above depth");

    no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (fill_reg != '0) && !gap_reg)
        else $error("pop from empty queue or during gap");

    exec_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !$past(cmd.add_write) && !$past(cmd.add_refuse))
        else $error("task step not preceded by tick");

    finish_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && task_finished) |-> !buzzer_on)
        else $error("finished task left buzzer on");

endmodule

// ===== rtl/core/beep_pattern_task_queue.sv =====
// ----------------------------------------------------------------------------
// beep_pattern_task_queue
// beeper sequencer with a ring queue of beep tasks
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  item in   start && !busy         op, beep_count, interval_10ms
//  result    done (one cycle)       add_accepted, buzzer_on, task_finished,
//                                   queue_level
//  config    cfg_valid && cfg_ready cfg_index, cfg_data
//
//  an add word gives its result in the next cycle; busy stays low
//  a tick word runs a queue read, then a task step; busy for one cycle
//  the split into read and step is set by the registered read of the task store
//  reset clears all control state; the task store holds no reset value
//  results cannot be stalled and are shown exactly one cycle
// ----------------------------------------------------------------------------
module beep_pattern_task_queue
    import bpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [COUNT_W-1:0]    beep_count,
    input  logic [IVL_W-1:0]      interval_10ms,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  add_accepted,
    output logic                  buzzer_on,
    output logic                  task_finished,
    output logic [LEVEL_W-1:0]    queue_level
);

    bpq_cmd_t    cmd;
    bpq_status_t status;

    assign cfg_ready = !busy;

    bpq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .beep_count    (beep_count),
        .interval_10ms (interval_10ms),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .add_accepted  (add_accepted),
        .buzzer_on     (buzzer_on),
        .task_finished (task_finished),
        .queue_level   (queue_level)
    );

endmodule

// ===== bench/beep_pattern_task_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_task_queue_tb
// self-checking bench for the beeper task queue
//
// A directed list comes first. It covers the tick after reset, filling the
// queue up to the refused add, the zero quantum and zero rate settings, and
// the extremes of the item fields and the quantum. Random phases follow, each
// under its own quantum and rate. The bench ends with a count-zero task that
// runs for 256 beeps before it ends. Typed rows are checked against fixed
// values, all other results against a behavioral sequencer model kept in step.
// ----------------------------------------------------------------------------
module beep_pattern_task_queue_tb;
    import bpq_pkg::*;

    localparam int DEPTH      = 10;
    localparam int CLK_PERIOD = 10;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int N_PHASES   = 7;

    typedef struct packed {
        logic               accepted;
        logic               buzzer;
        logic               finished;
        logic [LEVEL_W-1:0] level;
    } beep_report_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_SETTINGS
    } row_kind_t;

    // item rows: val_a = beep count, val_b = interval
    // settings rows: val_a = quantum, val_b = rate
    typedef struct packed {
        row_kind_t    kind;
        logic         op;
        logic [9:0]   val_a;
        logic [7:0]   val_b;
        logic         typed;
        beep_report_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [COUNT_W-1:0]    beep_count;
    logic [IVL_W-1:0]      interval_10ms;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic                  add_accepted;
    logic                  buzzer_on;
    logic                  task_finished;
    logic [LEVEL_W-1:0]    queue_level;

    // sequencer model state
    logic [TASK_W-1:0]    task_mem [DEPTH];
    int                   rd_ptr    = 0;
    int                   wr_ptr    = 0;
    int                   fill      = 0;
    logic [COUNT_W-1:0]   cur_count = '0;
    logic [IVL_W-1:0]     cur_ivl   = '0;
    logic [ELAPSED_W-1:0] elapsed   = '0;
    logic [7:0]           beeps     = '0;
    logic                 buzz      = 1'b0;
    logic                 last_over = 1'b1;
    logic                 gap_on    = 1'b0;
    logic [7:0]           gap_count = '0;
    logic [QUANTUM_W-1:0] quantum_reg = QUANTUM_RESET;
    logic [RATE_W-1:0]    rate_reg    = RATE_RESET;

    beep_report_t report_queue [$];
    int           error_count = 0;
    int           idle_pct    = 30;

    stim_row_t directed_rows [23] = '{
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b1, '{1'b0, 1'b0, 1'b1, 4'd0}},
        '{ROW_ITEM,     OP_ADD,  10'd0,    8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd1}},
        '{ROW_ITEM,     OP_ADD,  10'd1,    8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd2}},
        '{ROW_ITEM,     OP_ADD,  10'd255,  8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd3}},
        '{ROW_ITEM,     OP_ADD,  10'd0,    8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd4}},
        '{ROW_ITEM,     OP_ADD,  10'd1,    8'd255, 1'b1, '{1'b1, 1'b0, 1'b0, 4'd5}},
        '{ROW_ITEM,     OP_ADD,  10'd2,    8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd6}},
        '{ROW_ITEM,     OP_ADD,  10'd3,    8'd2,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd7}},
        '{ROW_ITEM,     OP_ADD,  10'd1,    8'd1,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd8}},
        '{ROW_ITEM,     OP_ADD,  10'd0,    8'd3,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd9}},
        '{ROW_ITEM,     OP_ADD,  10'd2,    8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 4'd10}},
        '{ROW_ITEM,     OP_ADD,  10'd255,  8'd255, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd10}},
        '{ROW_SETTINGS, OP_TICK, 10'd1023, 8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd255,  8'd255, 1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd170,  8'd85,  1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd85,   8'd170, 1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_SETTINGS, OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0},
        '{ROW_ITEM,     OP_TICK, 10'd0,    8'd0,   1'b0, '0}
    };

    int unsigned phase_quantum [N_PHASES] = '{40, 1, 250, 1023, 10, 700, 25};
    int unsigned phase_rate    [N_PHASES] = '{2, 1, 0, 255, 3, 1, 5};

    beep_pattern_task_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .beep_count   (beep_count),
        .interval_10ms(interval_10ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .add_accepted (add_accepted),
        .buzzer_on    (buzzer_on),
        .task_finished(task_finished),
        .queue_level  (queue_level)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    task automatic sequencer_step(input logic op_i, input logic [COUNT_W-1:0] cnt_i,
                                  input logic [IVL_W-1:0] ivl_i, output beep_report_t rep);
        int unsigned span;
        logic        fin;
        rep = '0;
        fin = 1'b0;
        if (op_i == OP_ADD)
        begin
            if (fill < DEPTH)
            begin
                task_mem[wr_ptr] = {cnt_i, ivl_i};
                wr_ptr = (wr_ptr + 1) % DEPTH;
                fill++;
                rep.accepted = 1'b1;
            end
        end
        else
        begin
            if (!gap_on && fill != 0 && last_over)
            begin
                {cur_count, cur_ivl} = task_mem[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
                fill--;
            end
            span = int'(cur_ivl) * 10;
            if ((cur_count == 0 && cur_ivl == 0) || span < quantum_reg)
            begin
                elapsed = '0;
                beeps   = '0;
                buzz    = 1'b0;
                fin     = 1'b1;
            end
            else
            begin
                elapsed = elapsed + ELAPSED_W'(quantum_reg);
                if (elapsed < span)
                    buzz = 1'b1;
                else if (elapsed < 2 * span)
                    buzz = 1'b0;
                else
                begin
                    elapsed = '0;
                    beeps   = beeps + 8'd1;
                    if (beeps == cur_count)
                    begin
                        buzz  = 1'b0;
                        beeps = '0;
                        fin   = 1'b1;
                    end
                end
            end
            last_over = fin;
            if (fin)
            begin
                cur_count = '0;
                cur_ivl   = '0;
                gap_on    = 1'b1;
            end
            if (gap_on)
            begin
                gap_count = gap_count + 8'd1;
                if (gap_count >= rate_reg)
                begin
                    gap_count = '0;
                    gap_on    = 1'b0;
                end
            end
        end
        rep.finished = fin;
        rep.buzzer   = buzz;
        rep.level    = LEVEL_W'(fill);
    endtask

    task automatic send_item(input logic op_i, input logic [COUNT_W-1:0] cnt_i,
                             input logic [IVL_W-1:0] ivl_i, input logic typed,
                             input beep_report_t want);
        beep_report_t rep;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        op            <= op_i;
        beep_count    <= cnt_i;
        interval_10ms <= ivl_i;
        do
            @(posedge clk);
        while (busy);
        sequencer_step(op_i, cnt_i, ivl_i, rep);
        report_queue.push_back(typed ? want : rep);
    endtask

    // writes both registers once the block has drained
    task automatic apply_settings(input logic [QUANTUM_W-1:0] q, input logic [RATE_W-1:0] r);
        start <= 1'b0;
        wait (report_queue.size() == 0);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_QUANTUM;
        cfg_data  <= CFG_DATA_W'(q);
        do
            @(posedge clk);
        while (!cfg_ready);
        quantum_reg = q;
        cfg_index <= CFG_RATE;
        cfg_data  <= CFG_DATA_W'(r);
        do
            @(posedge clk);
        while (!cfg_ready);
        rate_reg = r;
        cfg_valid <= 1'b0;
    endtask

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        beep_report_t got;
        beep_report_t want;
        if (rst_n && done)
        begin
            got = '{add_accepted, buzzer_on, task_finished, queue_level};
            if (report_queue.size() == 0)
                log_failure($sformatf("unexpected result word acc=%0d buz=%0d fin=%0d lvl=%0d",
                                      got.accepted, got.buzzer, got.finished, got.level));
            else
            begin
                want = report_queue.pop_front();
                if (got !== want)
                    log_failure($sformatf({"mismatch: expected acc=%0d buz=%0d fin=%0d lvl=%0d,",
                                           " got acc=%0d buz=%0d fin=%0d lvl=%0d"},
                                          want.accepted, want.buzzer, want.finished, want.level,
                                          got.accepted, got.buzzer, got.finished, got.level));
            end
        end
    end

    initial
    begin
        logic               rnd_op;
        logic [COUNT_W-1:0] rnd_count;
        logic [IVL_W-1:0]   rnd_ivl;
        int unsigned        pick;
        int unsigned        base;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        op            <= OP_TICK;
        beep_count    <= '0;
        interval_10ms <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_QUANTUM;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_SETTINGS)
                apply_settings(directed_rows[i].val_a, directed_rows[i].val_b);
            else
                send_item(directed_rows[i].op, directed_rows[i].val_a[7:0],
                          directed_rows[i].val_b, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            apply_settings(QUANTUM_W'(phase_quantum[p]), RATE_W'(phase_rate[p]));
            idle_pct = (p == 4) ? 0 : 30;
            repeat ((p == 4) ? 60 : 25)
            begin
                rnd_count = COUNT_W'($urandom_range(0, 255));
                rnd_ivl   = IVL_W'($urandom_range(0, 255));
                rnd_op    = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_TICK;
                if (rnd_op == OP_ADD)
                begin
                    pick = $urandom_range(0, 9);
                    base = (quantum_reg + 9) / 10;
                    // short beeps sized to the quantum, interval below quantum, empty task
                    if (pick < 6)
                    begin
                        rnd_count = COUNT_W'($urandom_range(1, 3));
                        rnd_ivl   = IVL_W'(base + $urandom_range(0, base));
                    end
                    else if (pick < 8)
                        rnd_ivl = IVL_W'($urandom_range(0, (quantum_reg - 1) / 10));
                    else
                    begin
                        rnd_count = '0;
                        rnd_ivl   = '0;
                    end
                end
                send_item(rnd_op, rnd_count, rnd_ivl, 1'b0, '0);
            end
        end

        // count zero: the beep counter wraps, the task ends after 256 beeps
        apply_settings(10'd1000, 8'd1);
        idle_pct = 30;
        for (int k = 0; k < 2000 && (fill != 0 || !last_over); k++)
            send_item(OP_TICK, COUNT_W'($urandom_range(0, 255)),
                      IVL_W'($urandom_range(0, 255)), 1'b0, '0);
        send_item(OP_ADD, 8'd0, 8'd100, 1'b0, '0);
        repeat (520)
            send_item(OP_TICK, COUNT_W'($urandom_range(0, 255)),
                      IVL_W'($urandom_range(0, 255)), 1'b0, '0);

        start <= 1'b0;
        wait (report_queue.size() == 0);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== beep_pattern_task_queue.f =====
rtl/core/bpq_pkg.sv
rtl/core/bpq_ram.sv
rtl/core/bpq_ctrl.sv
rtl/core/bpq_dp.sv
rtl/core/beep_pattern_task_queue.sv
bench/beep_pattern_task_queue_tb.sv
